// ===== sv/complex_arithmetic_unit_assert.svh =====
// Assertion macros shared by the checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, muted while reset is asserted.
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CAU_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared codes, defaults and the tag that travels with each transaction.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_DATA_WIDTH = 32;
    localparam int CAU_FRAC_BITS  = 16;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] OP_ADD = 3'd0;
    localparam logic [KIND_W-1:0] OP_SUB = 3'd1;
    localparam logic [KIND_W-1:0] OP_MUL = 3'd2;
    localparam logic [KIND_W-1:0] OP_DIV = 3'd3;
    localparam logic [KIND_W-1:0] OP_MAG = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic              neg_re;
        logic              neg_im;
        logic              sat;
        logic              dz;
    } t_tag;

endpackage

// ===== sv/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, magnitude.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one transaction (i_kind and the
// operands a and b, signed fixed point). Output channel: o_valid / i_stall
// carry o_res_re, o_res_im and o_status (ok, saturated, divide by zero).
// The path runs through three front stages (products, sums, sign and
// saturation prep), a chain of DATA_WIDTH + 2 cells that each settle one
// quotient or root bit, and the output register, for every operation.
// Throughput is one transaction per cycle while the receiver does not stall;
// every stage has its own valid bit, so bubbles are squeezed out and a new
// transaction is taken even while the output register waits.
// When the receiver stalls, the output holds and the stall ripples back
// stage by stage; o_stall rises only once every stage is occupied.
// Synchronous reset clears all valid bits; no results are pending after it.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cau_pkg::KIND_W-1:0]    i_kind,
    input  logic [DATA_WIDTH-1:0]         i_a_re,
    input  logic [DATA_WIDTH-1:0]         i_a_im,
    input  logic [DATA_WIDTH-1:0]         i_b_re,
    input  logic [DATA_WIDTH-1:0]         i_b_im,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [DATA_WIDTH-1:0]         o_res_re,
    output logic [DATA_WIDTH-1:0]         o_res_im,
    output logic [cau_pkg::STATUS_W-1:0]  o_status
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int XW = 3*W + FRAC_BITS + 1;
    localparam int QW = W + 2;
    localparam int NC = W + 2;   // cells, top one flags quotient overflow
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (W-1);

    // {sat, value} for a non-negative magnitude with a sign
    function automatic logic [W:0] f_pack(input logic neg, input logic [QW-1:0] m);
        logic [QW-1:0] t;
        t = QW'(0) - m;
        if (neg) begin
            if (m > HALF_Q) return {1'b1, HALF_Q[W-1:0]};
            return {1'b0, t[W-1:0]};
        end
        if (m > HALF_Q - QW'(1)) return {1'b1, HALF_Q[W-1:0] - W'(1)};
        return {1'b0, m[W-1:0]};
    endfunction

    // chain wiring, index 0 is the front's output
    logic           c_valid  [NC+1];
    logic           c_ready  [NC+1];
    t_tag           c_tag    [NC+1];
    logic [XW-1:0]  c_rem_re [NC+1];
    logic [XW-1:0]  c_rem_im [NC+1];
    logic [2*W-1:0] c_den    [NC+1];
    logic [QW-1:0]  c_q_re   [NC+1];
    logic [QW-1:0]  c_q_im   [NC+1];

    logic               en_o;
    logic               front_ready;
    logic               r_ov;
    logic [W-1:0]       r_res_re, r_res_im;
    logic [STATUS_W-1:0] r_status;
    logic [W-1:0]       n_res_re, n_res_im;
    logic [STATUS_W-1:0] n_status;
    logic [W:0]         pk_re, pk_im;
    t_tag               tl;

    cau_front #(.W(W), .F(FRAC_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_kind       (i_kind),
        .i_a_re       (i_a_re),
        .i_a_im       (i_a_im),
        .i_b_re       (i_b_re),
        .i_b_im       (i_b_im),
        .o_ready      (front_ready),
        .o_valid      (c_valid[0]),
        .o_tag        (c_tag[0]),
        .o_rem_re     (c_rem_re[0]),
        .o_rem_im     (c_rem_im[0]),
        .o_den        (c_den[0]),
        .o_q_re       (c_q_re[0]),
        .o_q_im       (c_q_im[0]),
        .i_ready_next (c_ready[0])
    );

    // cell i settles bit W+1-i
    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        cau_cell #(.W(W), .F(FRAC_BITS), .K(W + 1 - gi)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (c_valid[gi]),
            .i_tag        (c_tag[gi]),
            .i_rem_re     (c_rem_re[gi]),
            .i_rem_im     (c_rem_im[gi]),
            .i_den        (c_den[gi]),
            .i_q_re       (c_q_re[gi]),
            .i_q_im       (c_q_im[gi]),
            .o_ready      (c_ready[gi]),
            .o_valid      (c_valid[gi+1]),
            .o_tag        (c_tag[gi+1]),
            .o_rem_re     (c_rem_re[gi+1]),
            .o_rem_im     (c_rem_im[gi+1]),
            .o_den        (c_den[gi+1]),
            .o_q_re       (c_q_re[gi+1]),
            .o_q_im       (c_q_im[gi+1]),
            .i_ready_next (c_ready[gi+1])
        );
    end

    assign en_o        = !r_ov || !i_stall;
    assign c_ready[NC] = en_o;
    assign o_stall     = !front_ready;

    // final packing: divide and magnitude saturate here, the rest came packed
    always_comb begin
        tl       = c_tag[NC];
        pk_re    = f_pack(tl.neg_re, c_q_re[NC]);
        pk_im    = f_pack(tl.neg_im, c_q_im[NC]);
        n_res_re = '0;
        n_res_im = '0;
        n_status = ST_OK;
        unique case (tl.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_res_re = c_q_re[NC][W-1:0];
                n_res_im = c_q_im[NC][W-1:0];
                n_status = tl.sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (tl.dz) begin
                    n_status = ST_DZ;
                end else begin
                    n_res_re = pk_re[W-1:0];
                    n_res_im = pk_im[W-1:0];
                    n_status = (pk_re[W] | pk_im[W]) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                n_res_re = pk_re[W-1:0];
                n_status = pk_re[W] ? ST_SAT : ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_ov;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

endmodule

// ===== sv/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Products, sums and sign-magnitude preparation ahead of the cell chain.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int W = cau_pkg::CAU_DATA_WIDTH,
    parameter int F = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [cau_pkg::KIND_W-1:0] i_kind,
    input  logic [W-1:0]              i_a_re,
    input  logic [W-1:0]              i_a_im,
    input  logic [W-1:0]              i_b_re,
    input  logic [W-1:0]              i_b_im,
    output logic                      o_ready,
    output logic                      o_valid,
    output cau_pkg::t_tag             o_tag,
    output logic [3*W+F:0]            o_rem_re,
    output logic [3*W+F:0]            o_rem_im,
    output logic [2*W-1:0]            o_den,
    output logic [W+1:0]              o_q_re,
    output logic [W+1:0]              o_q_im,
    input  logic                      i_ready_next
);
    import cau_pkg::*;

    localparam int XW = 3*W + F + 1;
    localparam int PW = 2*W;
    localparam int VW = 2*W + 2;
    localparam int QW = W + 2;
    localparam logic [VW-1:0] HALF_V = VW'(1) << (W-1);

    // saturating pack of a sign-magnitude value, {sat, value}
    function automatic logic [W:0] f_pack(input logic neg, input logic [VW-1:0] m);
        logic [VW-1:0] t;
        t = VW'(0) - m;
        if (neg) begin
            if (m > HALF_V) return {1'b1, HALF_V[W-1:0]};
            return {1'b0, t[W-1:0]};
        end
        if (m > HALF_V - VW'(1)) return {1'b1, HALF_V[W-1:0] - W'(1)};
        return {1'b0, m[W-1:0]};
    endfunction

    function automatic logic signed [VW-1:0] f_px(input logic [PW-1:0] p);
        return {{2{p[PW-1]}}, p};
    endfunction

    function automatic logic signed [VW-1:0] f_sx(input logic [W:0] s);
        return {{(VW-W-1){s[W]}}, s};
    endfunction

    logic en_p, en_s, en_m;

    // products stage
    logic                     r_p_v;
    logic [KIND_W-1:0]        r_p_op;
    logic signed [PW-1:0]     r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [W:0]               r_p_sum_re, r_p_sum_im;
    logic signed [PW-1:0]     n_p0, n_p1, n_p2, n_p3, n_p4, n_p5;
    logic [W:0]               n_p_sum_re, n_p_sum_im;
    logic [W-1:0]             sq_x, sq_y;

    // sums stage
    logic                     r_s_v;
    logic [KIND_W-1:0]        r_s_op;
    logic signed [VW-1:0]     r_s_val_re, r_s_val_im;
    logic [PW-1:0]            r_s_den;
    logic signed [VW-1:0]     n_s_val_re, n_s_val_im;

    // preparation stage
    logic                     r_m_v;
    t_tag                     r_m_tag;
    logic [XW-1:0]            r_m_rem_re, r_m_rem_im;
    logic [PW-1:0]            r_m_den;
    logic [QW-1:0]            r_m_q_re, r_m_q_im;
    t_tag                     n_m_tag;
    logic [XW-1:0]            n_m_rem_re, n_m_rem_im;
    logic [QW-1:0]            n_m_q_re, n_m_q_im;
    logic                     neg_re, neg_im;
    logic [VW-1:0]            mag_re, mag_im, m_re, m_im;
    logic [W:0]               pk_re, pk_im;

    assign en_m    = !r_m_v || i_ready_next;
    assign en_s    = !r_s_v || en_m;
    assign en_p    = !r_p_v || en_s;
    assign o_ready = en_p;

    always_comb begin
        sq_x = (i_kind == OP_MAG) ? i_a_re : i_b_re;
        sq_y = (i_kind == OP_MAG) ? i_a_im : i_b_im;
        n_p0 = $signed(i_a_re) * $signed(i_b_re);
        n_p1 = $signed(i_a_im) * $signed(i_b_im);
        n_p2 = $signed(i_a_re) * $signed(i_b_im);
        n_p3 = $signed(i_a_im) * $signed(i_b_re);
        n_p4 = $signed(sq_x) * $signed(sq_x);
        n_p5 = $signed(sq_y) * $signed(sq_y);
        if (i_kind == OP_SUB) begin
            n_p_sum_re = {i_a_re[W-1], i_a_re} - {i_b_re[W-1], i_b_re};
            n_p_sum_im = {i_a_im[W-1], i_a_im} - {i_b_im[W-1], i_b_im};
        end else begin
            n_p_sum_re = {i_a_re[W-1], i_a_re} + {i_b_re[W-1], i_b_re};
            n_p_sum_im = {i_a_im[W-1], i_a_im} + {i_b_im[W-1], i_b_im};
        end
    end

    always_comb begin
        unique case (r_p_op)
            OP_ADD, OP_SUB: begin
                n_s_val_re = f_sx(r_p_sum_re);
                n_s_val_im = f_sx(r_p_sum_im);
            end
            OP_MUL: begin
                n_s_val_re = f_px(r_p0) - f_px(r_p1);
                n_s_val_im = f_px(r_p2) + f_px(r_p3);
            end
            OP_DIV: begin
                n_s_val_re = f_px(r_p0) + f_px(r_p1);
                n_s_val_im = f_px(r_p3) - f_px(r_p2);
            end
            default: begin
                n_s_val_re = '0;
                n_s_val_im = '0;
            end
        endcase
    end

    always_comb begin
        neg_re = r_s_val_re[VW-1];
        neg_im = r_s_val_im[VW-1];
        mag_re = neg_re ? VW'(0) - r_s_val_re : r_s_val_re;
        mag_im = neg_im ? VW'(0) - r_s_val_im : r_s_val_im;
        m_re   = (r_s_op == OP_MUL) ? mag_re >> F : mag_re;
        m_im   = (r_s_op == OP_MUL) ? mag_im >> F : mag_im;
        pk_re  = f_pack(neg_re, m_re);
        pk_im  = f_pack(neg_im, m_im);

        n_m_tag        = '0;
        n_m_tag.op     = r_s_op;
        n_m_rem_re     = '0;
        n_m_rem_im     = '0;
        n_m_q_re       = '0;
        n_m_q_im       = '0;
        unique case (r_s_op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_m_q_re    = QW'(pk_re[W-1:0]);
                n_m_q_im    = QW'(pk_im[W-1:0]);
                n_m_tag.sat = pk_re[W] | pk_im[W];
            end
            OP_DIV: begin
                n_m_rem_re     = XW'(mag_re) << F;
                n_m_rem_im     = XW'(mag_im) << F;
                n_m_tag.neg_re = neg_re;
                n_m_tag.neg_im = neg_im;
                n_m_tag.dz     = (r_s_den == '0);
            end
            OP_MAG: begin
                n_m_rem_re = XW'(r_s_den);
            end
            default: begin
                n_m_tag.sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_s_v <= 1'b0;
            r_m_v <= 1'b0;
        end else begin
            if (en_p) r_p_v <= i_valid;
            if (en_s) r_s_v <= r_p_v;
            if (en_m) r_m_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_p_op     <= i_kind;
            r_p0       <= n_p0;
            r_p1       <= n_p1;
            r_p2       <= n_p2;
            r_p3       <= n_p3;
            r_p4       <= n_p4;
            r_p5       <= n_p5;
            r_p_sum_re <= n_p_sum_re;
            r_p_sum_im <= n_p_sum_im;
        end
        if (en_s) begin
            r_s_op     <= r_p_op;
            r_s_val_re <= n_s_val_re;
            r_s_val_im <= n_s_val_im;
            r_s_den    <= r_p4 + r_p5;
        end
        if (en_m) begin
            r_m_tag    <= n_m_tag;
            r_m_rem_re <= n_m_rem_re;
            r_m_rem_im <= n_m_rem_im;
            r_m_den    <= r_s_den;
            r_m_q_re   <= n_m_q_re;
            r_m_q_im   <= n_m_q_im;
        end
    end

    assign o_valid  = r_m_v;
    assign o_tag    = r_m_tag;
    assign o_rem_re = r_m_rem_re;
    assign o_rem_im = r_m_rem_im;
    assign o_den    = r_m_den;
    assign o_q_re   = r_m_q_re;
    assign o_q_im   = r_m_q_im;

endmodule

// ===== sv/cau_cell.sv =====
// ----------------------------------------------------------------------------
// cau_cell
// One quotient bit of both divide lanes, or one root bit of the square root.
// ----------------------------------------------------------------------------
module cau_cell #(
    parameter int W = cau_pkg::CAU_DATA_WIDTH,
    parameter int F = cau_pkg::CAU_FRAC_BITS,
    parameter int K = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cau_pkg::t_tag    i_tag,
    input  logic [3*W+F:0]   i_rem_re,
    input  logic [3*W+F:0]   i_rem_im,
    input  logic [2*W-1:0]   i_den,
    input  logic [W+1:0]     i_q_re,
    input  logic [W+1:0]     i_q_im,
    output logic             o_ready,
    output logic             o_valid,
    output cau_pkg::t_tag    o_tag,
    output logic [3*W+F:0]   o_rem_re,
    output logic [3*W+F:0]   o_rem_im,
    output logic [2*W-1:0]   o_den,
    output logic [W+1:0]     o_q_re,
    output logic [W+1:0]     o_q_im,
    input  logic             i_ready_next
);
    import cau_pkg::*;

    localparam int XW = 3*W + F + 1;
    localparam int QW = W + 2;
    localparam bit SQ_STEP = (K < W);

    logic          en;
    logic          r_v;
    t_tag          r_tag;
    logic [XW-1:0] r_rem_re, r_rem_im;
    logic [2*W-1:0] r_den;
    logic [QW-1:0] r_q_re, r_q_im;
    logic [XW-1:0] n_rem_re, n_rem_im;
    logic [QW-1:0] n_q_re, n_q_im;
    logic [XW-1:0] dsh, trial;

    assign en      = !r_v || i_ready_next;
    assign o_ready = en;

    always_comb begin
        dsh      = XW'(i_den) << K;
        trial    = (XW'(i_q_re) << (K+1)) + (XW'(1) << (2*K));
        n_rem_re = i_rem_re;
        n_rem_im = i_rem_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        unique case (i_tag.op)
            OP_DIV: begin
                if (i_rem_re >= dsh) begin
                    n_rem_re  = i_rem_re - dsh;
                    n_q_re[K] = 1'b1;
                end
                if (i_rem_im >= dsh) begin
                    n_rem_im  = i_rem_im - dsh;
                    n_q_im[K] = 1'b1;
                end
            end
            OP_MAG: begin
                if (SQ_STEP && i_rem_re >= trial) begin
                    n_rem_re  = i_rem_re - trial;
                    n_q_re[K] = 1'b1;
                end
            end
            default: begin
                n_q_re = i_q_re;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag    <= i_tag;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_den    <= i_den;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
        end
    end

    assign o_valid  = r_v;
    assign o_tag    = r_tag;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_den    = r_den;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule

// ===== sv/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module cau_checker #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [DATA_WIDTH-1:0]        o_res_re,
    input logic [DATA_WIDTH-1:0]        o_res_im,
    input logic [cau_pkg::STATUS_W-1:0] o_status
);
    import cau_pkg::*;

    // status is one of the three defined outcomes
    `CAU_ASSERT_IMPL(a_status_code, o_valid, o_status == ST_OK || o_status == ST_SAT || o_status == ST_DZ, "undefined status")

    // divide by zero leaves both parts at zero
    `CAU_ASSERT_IMPL(a_dz_zero, o_valid && o_status == ST_DZ, o_res_re == '0 && o_res_im == '0, "nonzero result on divide by zero")

    // a stalled transaction stays put
    `CAU_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_res_re) && $stable(o_res_im) && $stable(o_status), "stalled result moved")

    // nothing comes out right after reset
    `CAU_ASSERT_NEXT_RST(a_reset_empty, !i_rst_n, !o_valid, "result after reset")

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_res_re (o_res_re),
    .o_res_im (o_res_im),
    .o_status (o_status)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for complex_arithmetic_unit: a queue-fed driver, a
// random stalling receiver, a bit-exact fixed-point predictor and a monitor
// that compares every result transaction, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import cau_pkg::*;

    localparam int DW         = CAU_DATA_WIDTH;
    localparam int FB         = CAU_FRAC_BITS;
    localparam int HOLD_LEN   = 150;   // long receiver hold-off, in cycles
    localparam int WDOG_LIMIT = 3000;  // idle cycles before giving up
    localparam int TAIL_WAIT  = 60;    // tail wait, longer than the pipeline latency

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DW-1:0]     a_re, a_im, b_re, b_im;
    } t_op_item;

    typedef struct {
        logic [DW-1:0]       re, im;
        logic [STATUS_W-1:0] st;
    } t_cx_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [DW-1:0]       i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DW-1:0]       o_res_re, o_res_im;
    logic [STATUS_W-1:0] o_status;

    t_op_item   pending_ops[$];
    t_cx_result owed_results[$];

    int  n_errors    = 0;
    bit  calm        = 1'b0;   // no idling on either side once set
    bit  in_took     = 1'b0;   // input transaction taken at the last edge
    int  send_gap    = 0;
    int  hold_ask    = 0;      // bumped by the stimulus to request a long hold
    int  hold_served = 0;
    int  hold_cnt    = 0;
    int  stall_burst = 0;
    int  idle_cycles = 0;

    complex_arithmetic_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------------

    // Clamp to the signed data range; bit DW flags saturation.
    function automatic logic [DW:0] clamp_part(input t_wide v);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (DW - 1)) - 1;
        lo = -(t_wide'(1) <<< (DW - 1));
        if (v > hi) return {1'b1, hi[DW-1:0]};
        if (v < lo) return {1'b1, lo[DW-1:0]};
        return {1'b0, v[DW-1:0]};
    endfunction

    // Floor of the square root, classic digit-by-digit method.
    function automatic t_wide floor_sqrt(input t_wide s);
        t_wide root, b;
        root = 0;
        b = t_wide'(1) <<< 126;
        while (b > s) b = b >>> 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s = s - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    // Exact arithmetic in 128 bits; SV signed division truncates toward zero,
    // which is just what products and quotients need here.
    function automatic t_cx_result cx_compute(input t_op_item it);
        t_cx_result r;
        t_wide ar, ai, br, bi, den, vre, vim;
        logic [DW:0] pr, pi;
        ar = t_wide'($signed(it.a_re));
        ai = t_wide'($signed(it.a_im));
        br = t_wide'($signed(it.b_re));
        bi = t_wide'($signed(it.b_im));
        r.re = '0;
        r.im = '0;
        r.st = ST_OK;
        pr = '0;
        pi = '0;
        case (it.kind)
            OP_ADD: begin
                pr = clamp_part(ar + br);
                pi = clamp_part(ai + bi);
            end
            OP_SUB: begin
                pr = clamp_part(ar - br);
                pi = clamp_part(ai - bi);
            end
            OP_MUL: begin
                vre = (ar * br - ai * bi) / (t_wide'(1) <<< FB);
                vim = (ar * bi + ai * br) / (t_wide'(1) <<< FB);
                pr = clamp_part(vre);
                pi = clamp_part(vim);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.st = ST_DZ;
                end else begin
                    vre = ((ar * br + ai * bi) <<< FB) / den;
                    vim = ((ai * br - ar * bi) <<< FB) / den;
                    pr = clamp_part(vre);
                    pi = clamp_part(vim);
                end
            end
            OP_MAG: begin
                pr = clamp_part(floor_sqrt(ar * ar + ai * ai));
            end
            default: ;  // unused codes give all zeros
        endcase
        if (r.st != ST_DZ) begin
            r.re = pr[DW-1:0];
            r.im = pi[DW-1:0];
            if (pr[DW] || pi[DW]) r.st = ST_SAT;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Biased operand part: extremes, zero, small values and full-range noise.
    function automatic logic [DW-1:0] pick_part();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'b0, {(DW-1){1'b1}}};
            1: v = {1'b1, {(DW-1){1'b0}}};
            2: v = '0;
            3: v = DW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            4: v = $urandom_range(0, 1) ? DW'(1 << FB) : DW'(-(1 << FB));
            5: v = DW'($signed($urandom_range(0, 511)) - 256);
            default: v = DW'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_op_item pick_item();
        t_op_item it;
        it.kind = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(5, 7))
                                                : KIND_W'($urandom_range(0, 4));
        it.a_re = pick_part();
        it.a_im = pick_part();
        it.b_re = pick_part();
        it.b_im = pick_part();
        if (it.kind == OP_DIV && $urandom_range(0, 9) == 0) begin
            it.b_re = '0;
            it.b_im = '0;
        end
        return it;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] k, input logic [DW-1:0] ar,
                            input logic [DW-1:0] ai, input logic [DW-1:0] br,
                            input logic [DW-1:0] bi);
        t_op_item it;
        it.kind = k;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        pending_ops.push_back(it);
    endtask

    // polled once a cycle so queue changes are always seen
    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_valid || owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the next queued transaction on the falling edge.
    // A transaction is held until taken; gaps come in random bursts.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_op_item it;
        if (i_rst_n && (!i_valid || in_took)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                it = pending_ops.pop_front();
                i_kind  <= it.kind;
                i_a_re  <= it.a_re;
                i_a_im  <= it.a_im;
                i_b_re  <= it.b_re;
                i_b_im  <= it.b_im;
                i_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 15);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request so the
    // pipeline fills and pushes back on the input.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else if (hold_served != hold_ask) begin
            hold_served <= hold_ask;
            hold_cnt    <= HOLD_LEN - 1;
            i_stall     <= 1'b1;
        end else if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_stall     <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_burst <= $urandom_range(0, 14);
            i_stall     <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: books the expected result of every taken input transaction
    // and checks every taken output transaction against the oldest one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_op_item   it;
        t_cx_result want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                it.kind = i_kind;
                it.a_re = i_a_re;
                it.a_im = i_a_im;
                it.b_re = i_b_re;
                it.b_im = i_b_im;
                owed_results.push_back(cx_compute(it));
            end
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: re=%h im=%h status=%0d",
                           o_res_re, o_res_im, o_status);
                    n_errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_res_re !== want.re) begin
                        $error("res_re: expected %h, got %h", want.re, o_res_re);
                        n_errors++;
                    end
                    if (o_res_im !== want.im) begin
                        $error("res_im: expected %h, got %h", want.im, o_res_im);
                        n_errors++;
                    end
                    if (o_status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, o_status);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no transaction on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("complex_arithmetic_unit regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DW-1:0] vmax, vmin, one, zero;
        vmax = {1'b0, {(DW-1){1'b1}}};
        vmin = {1'b1, {(DW-1){1'b0}}};
        one  = DW'(1 << FB);
        zero = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each operation, saturation, divide by zero,
        // magnitude overflow and the unused codes.
        queue_op(OP_ADD, vmax, vmin, vmax, vmin);    // both parts saturate
        queue_op(OP_ADD, one, DW'(-1), DW'(-1), one);
        queue_op(OP_SUB, vmin, vmax, vmax, vmin);    // saturate both ways
        queue_op(OP_SUB, one, one, one, one);
        queue_op(OP_MUL, vmax, vmax, vmax, vmax);
        queue_op(OP_MUL, vmin, vmin, vmin, vmin);
        queue_op(OP_MUL, DW'(-3), DW'(5), DW'(7), DW'(-11));  // truncation
        queue_op(OP_MUL, one, zero, zero, one);
        queue_op(OP_DIV, one, zero, zero, zero);     // divide by zero
        queue_op(OP_DIV, vmax, vmax, zero, zero);
        queue_op(OP_DIV, one, zero, DW'(3 << FB), zero);
        queue_op(OP_DIV, vmin, vmin, DW'(1), DW'(1));
        queue_op(OP_DIV, DW'(-(1 << FB)), one, DW'(3 << FB), DW'(-(2 << FB)));
        queue_op(OP_DIV, vmax, vmin, vmin, vmax);
        queue_op(OP_MAG, vmin, vmin, zero, zero);    // magnitude overflows
        queue_op(OP_MAG, zero, zero, vmax, vmax);
        queue_op(OP_MAG, DW'(3 << FB), DW'(-(4 << FB)), zero, zero);
        queue_op(OP_MAG, DW'(2), DW'(0), zero, zero);
        queue_op(KIND_W'(5), vmax, vmax, vmax, vmax);
        queue_op(KIND_W'(6), vmin, one, one, vmin);
        queue_op(KIND_W'(7), one, one, one, one);

        // Sender pause until every result of the directed part is back.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        hold_ask++;
        repeat (250) pending_ops.push_back(pick_item());
        while (pending_ops.size() >= 50) @(posedge i_clk);

        repeat (530) pending_ops.push_back(pick_item());
        while (pending_ops.size() >= 120) @(posedge i_clk);
        calm = 1'b1;

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (n_errors == 0 && owed_results.size() == 0)
            $display("complex_arithmetic_unit regression: pass");
        else
            $display("complex_arithmetic_unit regression: fail");
        $finish;
    end

endmodule
